// ===== design/lfr_pkg.sv =====
// shared constants and types for the limited face reconstruction block
package lfr_pkg;

  localparam int VW   = 32;            // value width
  localparam int FB   = 16;            // weight fraction bits
  localparam int CFGW = 31;            // threshold register width
  localparam int MW   = VW;            // neighbor difference magnitude width
  localparam int FW   = FB + 1;        // ratio / weight width, holds 1.0
  localparam int NW   = 2 * FB + 1;    // weight numerator / denominator width
  localparam int R1W  = MW + 1;        // first divider remainder width
  localparam int R2W  = NW + 1;        // second divider remainder width
  localparam int PW   = FW + MW;       // weight times difference width
  localparam int SH   = FB + 2;        // quarter weight scaling shift
  localparam int CW   = MW + CFGW;     // threshold compare width
  localparam int D1N  = FB + 2;        // first divider steps
  localparam int D2N  = FB + 2;        // second divider steps
  localparam int NS   = D1N + D2N + 4; // stages that carry sideband
  localparam int LAT  = NS + 1;        // pipeline depth from input to output register

  typedef struct packed {
    logic signed [VW-1:0] c;
    logic                 dneg;
    logic                 ok;
    logic [MW-1:0]        dm;
  } side_t;

endpackage

// ===== design/lfr_if.sv =====
// input and output channel interfaces
interface lfr_in_if;
  import lfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] pres_west;
  logic signed [VW-1:0] pres_center;
  logic signed [VW-1:0] pres_east;
  logic signed [VW-1:0] temp_west;
  logic signed [VW-1:0] temp_center;
  logic signed [VW-1:0] temp_east;

  modport source (output valid, pres_west, pres_center, pres_east,
                  temp_west, temp_center, temp_east, input ready);
  modport sink   (input valid, pres_west, pres_center, pres_east,
                  temp_west, temp_center, temp_east, output ready);
endinterface

interface lfr_out_if;
  import lfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] pres_west_face;
  logic signed [VW-1:0] pres_east_face;
  logic signed [VW-1:0] temp_west_face;
  logic signed [VW-1:0] temp_east_face;
  logic                 pres_limited;
  logic                 temp_limited;

  modport source (output valid, pres_west_face, pres_east_face, temp_west_face,
                  temp_east_face, pres_limited, temp_limited, input ready);
  modport sink   (input valid, pres_west_face, pres_east_face, temp_west_face,
                  temp_east_face, pres_limited, temp_limited, output ready);
endinterface

// ===== design/lfr_lane.sv =====
// one quantity's limiter datapath: tests, two pipelined dividers, face values
module lfr_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lfr_pkg::CFGW-1:0]     thr_i,
  input  logic signed [lfr_pkg::VW-1:0] w_i,
  input  logic signed [lfr_pkg::VW-1:0] c_i,
  input  logic signed [lfr_pkg::VW-1:0] e_i,
  output logic signed [lfr_pkg::VW-1:0] west_face_o,
  output logic signed [lfr_pkg::VW-1:0] east_face_o,
  output logic                         limited_o
);
  import lfr_pkg::*;

  side_t                side_q [NS];
  logic [MW-1:0]        am_q;
  logic [R1W-1:0]       r1_q   [D1N];
  logic [FW-1:0]        q1_q   [D1N];
  logic [2*FW-1:0]      ff_q, gg_q, fg_q;
  logic [NW-1:0]        num_q;
  logic [NW-1:0]        den_q  [D2N+1];
  logic [R2W-1:0]       r2_q   [D2N];
  logic [FW-1:0]        q2_q   [D2N];
  logic [PW-1:0]        prod_q;
  logic signed [VW-1:0] wface_q, eface_q;
  logic                 lim_q;

  // entry tests
  logic signed [VW:0] lo, hi, d;
  logic [VW:0]        dabs, aabs;
  logic               between, big;

  always_comb begin
    lo      = $signed({e_i[VW-1], e_i}) - $signed({c_i[VW-1], c_i});
    hi      = $signed({c_i[VW-1], c_i}) - $signed({w_i[VW-1], w_i});
    d       = $signed({e_i[VW-1], e_i}) - $signed({w_i[VW-1], w_i});
    dabs    = d[VW] ? -d : d;
    aabs    = hi[VW] ? -hi : hi;
    between = (lo > 0 && hi > 0) || (lo < 0 && hi < 0);
    big     = CW'(dabs[MW-1:0]) > CW'(thr_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].c    <= c_i;
      side_q[0].dneg <= d[VW];
      side_q[0].ok   <= between && big;
      side_q[0].dm   <= dabs[MW-1:0];
      am_q           <= aabs[MW-1:0];
    end
  end

  // f = round(am / dm) in Q0.FB, one quotient bit per stage
  for (genvar k = 0; k < D1N; k++) begin : g_div1
    logic [R1W-1:0] rsh;
    logic [FW-1:0]  qin;
    logic           ge;
    if (k == 0) begin : g_first
      assign rsh = R1W'(am_q);
      assign qin = '0;
    end else begin : g_next
      assign rsh = {r1_q[k-1][R1W-2:0], 1'b0};
      assign qin = q1_q[k-1];
    end
    assign ge = rsh >= R1W'(side_q[k].dm);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r1_q[k]     <= ge ? rsh - R1W'(side_q[k].dm) : rsh;
        if (k == D1N - 1) begin
          q1_q[k] <= qin + FW'(ge);
        end else begin
          q1_q[k] <= {qin[FW-2:0], ge};
        end
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // squares and cross product of f and 1-f
  logic [FW-1:0] f, g;
  assign f = q1_q[D1N-1];
  assign g = FW'(1 << FB) - f;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ff_q          <= f * f;
      gg_q          <= g * g;
      fg_q          <= f * g;
      side_q[D1N+1] <= side_q[D1N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q         <= NW'({fg_q, 1'b0});
      den_q[0]      <= NW'(ff_q + gg_q);
      side_q[D1N+2] <= side_q[D1N+1];
    end
  end

  // wf = round(2fg / (f^2 + g^2)) in Q0.FB
  for (genvar k = 0; k < D2N; k++) begin : g_div2
    logic [R2W-1:0] rsh;
    logic [FW-1:0]  qin;
    logic           ge;
    if (k == 0) begin : g_first
      assign rsh = R2W'(num_q);
      assign qin = '0;
    end else begin : g_next
      assign rsh = {r2_q[k-1][R2W-2:0], 1'b0};
      assign qin = q2_q[k-1];
    end
    assign ge = rsh >= R2W'(den_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r2_q[k]  <= ge ? rsh - R2W'(den_q[k]) : rsh;
        if (k == D2N - 1) begin
          q2_q[k] <= qin + FW'(ge);
        end else begin
          q2_q[k] <= {qin[FW-2:0], ge};
        end
        den_q[k+1]          <= den_q[k];
        side_q[D1N+3+k]     <= side_q[D1N+2+k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= PW'(q2_q[D2N-1]) * PW'(side_q[NS-2].dm);
      side_q[NS-1] <= side_q[NS-2];
    end
  end

  // quarter offset, signed faces with saturation
  logic [PW:0]        rnd;
  logic [MW-1:0]      delta;
  logic signed [VW:0] cx, dx, wsum, esum;
  logic signed [VW-1:0] wsat, esat;
  localparam logic signed [VW:0] VMAXX = (VW+1)'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [VW:0] VMINX = -VMAXX - 1;

  always_comb begin
    rnd   = {1'b0, prod_q} + (PW+1)'(1 << (SH - 1));
    delta = rnd[SH +: MW];
    cx    = $signed({side_q[NS-1].c[VW-1], side_q[NS-1].c});
    dx    = $signed((VW+1)'(delta));
    wsum  = side_q[NS-1].dneg ? cx + dx : cx - dx;
    esum  = side_q[NS-1].dneg ? cx - dx : cx + dx;
    wsat  = wsum > VMAXX ? VMAXX[VW-1:0] : (wsum < VMINX ? VMINX[VW-1:0] : wsum[VW-1:0]);
    esat  = esum > VMAXX ? VMAXX[VW-1:0] : (esum < VMINX ? VMINX[VW-1:0] : esum[VW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wface_q <= side_q[NS-1].ok ? wsat : side_q[NS-1].c;
      eface_q <= side_q[NS-1].ok ? esat : side_q[NS-1].c;
      lim_q   <= side_q[NS-1].ok;
    end
  end

  assign west_face_o = wface_q;
  assign east_face_o = eface_q;
  assign limited_o   = lim_q;

endmodule

// ===== design/limited_face_reconstruction.sv =====
// top level of the limited face reconstruction block
//
//  channel  dir  handshake      word
//  in_i     in   valid/ready    west, center, east of pressure and temperature
//  out_o    out  valid/ready    west and east faces of both, two limited flags
//  cfg      in   cfg_we_i       min_neighbor_diff, 31 bits
//
// one word per cycle while not stalled; the latency comes mostly from the two
// restoring dividers that resolve one quotient bit per stage
// the whole pipeline advances together; it holds when the output word is
// not taken, and in_i.ready drops only then, so nothing is lost or repeated
// reset clears the valid bits and the threshold; data registers are not reset
module limited_face_reconstruction (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lfr_pkg::CFGW-1:0] cfg_wdata_i,
  lfr_in_if.sink                   in_i,
  lfr_out_if.source                out_o
);
  import lfr_pkg::*;

  logic [CFGW-1:0] thr_q;
  logic [LAT-1:0]  valid_q;
  logic            en;

  // advance unless the output word is held
  assign en       = !valid_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // valid bits run alongside the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_i.valid};
    end
  end

  lfr_lane u_pres (
    .clk_i      (clk_i),
    .en_i       (en),
    .thr_i      (thr_q),
    .w_i        (in_i.pres_west),
    .c_i        (in_i.pres_center),
    .e_i        (in_i.pres_east),
    .west_face_o(out_o.pres_west_face),
    .east_face_o(out_o.pres_east_face),
    .limited_o  (out_o.pres_limited)
  );

  lfr_lane u_temp (
    .clk_i      (clk_i),
    .en_i       (en),
    .thr_i      (thr_q),
    .w_i        (in_i.temp_west),
    .c_i        (in_i.temp_center),
    .e_i        (in_i.temp_east),
    .west_face_o(out_o.temp_west_face),
    .east_face_o(out_o.temp_east_face),
    .limited_o  (out_o.temp_limited)
  );

  assign out_o.valid = valid_q[LAT-1];

endmodule

// ===== design/lfr_checker.sv =====
// port level checks for the limited face reconstruction block
module lfr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [lfr_pkg::VW-1:0] pw_i,
  input logic signed [lfr_pkg::VW-1:0] pe_i,
  input logic signed [lfr_pkg::VW-1:0] tw_i,
  input logic signed [lfr_pkg::VW-1:0] te_i,
  input logic                      pl_i,
  input logic                      tl_i
);
  import lfr_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a held output word");

  a_pres_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pl_i |-> pw_i == pe_i)
    else $error("pressure faces differ without reconstruction");

  a_temp_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !tl_i |-> tw_i == te_i)
    else $error("temperature faces differ without reconstruction");

endmodule

bind limited_face_reconstruction lfr_checker u_lfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .pw_i       (out_o.pres_west_face),
  .pe_i       (out_o.pres_east_face),
  .tw_i       (out_o.temp_west_face),
  .te_i       (out_o.temp_east_face),
  .pl_i       (out_o.pres_limited),
  .tl_i       (out_o.temp_limited)
);
